// File: src/pal_pkg.sv
// Shared types, constants and mode codes for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd50;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [CNT_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } pal_in_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] result_value;
        logic [CNT_W-1:0]         found_position;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
        logic                     is_full;
    } pal_out_t;

    typedef struct packed {
        logic              rd_en;
        logic              find_en;
        logic              hit;
        logic [IDX_W-1:0]  target;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] rval;
        logic [IDX_W-1:0]  fpos;
    } pal_token_t;

    typedef struct packed {
        logic              up;
        logic              down;
        logic [IDX_W-1:0]  target;
        logic [DATA_W-1:0] value;
    } pal_shift_t;

endpackage

// File: src/pal_cell.sv
// One list cell: holds an entry, shifts with its neighbors and probes the passing query.
`timescale 1ns / 1ps

module pal_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pal_pkg::IDX_W-1:0]  cell_index,
    input  logic [pal_pkg::CNT_W-1:0]  count,
    input  pal_pkg::pal_shift_t        shift,
    input  logic [pal_pkg::DATA_W-1:0] left_entry,
    input  logic [pal_pkg::DATA_W-1:0] right_entry,
    output logic [pal_pkg::DATA_W-1:0] entry,
    input  logic                       tok_valid_in,
    input  pal_pkg::pal_token_t        tok_in,
    output logic                       tok_valid_out,
    output pal_pkg::pal_token_t        tok_out
);
    import pal_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              tok_valid_reg;
    pal_token_t        tok_reg;
    pal_token_t        tok_next;
    logic              live;

    assign live = {{(CNT_W-IDX_W){1'b0}}, cell_index} < count;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift.up)
        begin
            if (cell_index > shift.target)
            begin
                entry_next = left_entry;
            end
            else if (cell_index == shift.target)
            begin
                entry_next = shift.value;
            end
        end
        else if (shift.down)
        begin
            if (cell_index >= shift.target)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.rd_en && (tok_in.target == cell_index))
        begin
            tok_next.rval = entry_reg;
        end
        if (tok_in.find_en && !tok_in.hit && live && (entry_reg == tok_in.value))
        begin
            tok_next.hit  = 1'b1;
            tok_next.rval = entry_reg;
            tok_next.fpos = cell_index;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tok_reg   <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    assign entry         = entry_reg;
    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// File: src/pal_ctrl.sv
// Request sequencer: checks positions, launches the query, commits shifts and results.
`timescale 1ns / 1ps

module pal_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  pal_pkg::pal_in_t           in_req,
    output logic                       out_valid,
    input  logic                       out_stall,
    output pal_pkg::pal_out_t          out_res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pal_pkg::CNT_W-1:0]  cfg_data,
    output logic                       launch_valid,
    output pal_pkg::pal_token_t        launch_tok,
    input  logic                       done_valid,
    input  pal_pkg::pal_token_t        done_tok,
    output pal_pkg::pal_shift_t        shift,
    output logic [pal_pkg::CNT_W-1:0]  count
);
    import pal_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              ok_reg;
    logic [IDX_W-1:0]  target_reg;
    logic [DATA_W-1:0] value_reg;
    pal_token_t        res_reg;
    logic              out_valid_reg;
    pal_out_t          out_reg;
    pal_out_t          out_next;

    logic              accept;
    logic              commit;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  pos_m1;
    logic              pos_ok;
    logic              ins_ok;
    logic              op_ok;
    logic              res_ok;
    logic              is_ins;
    logic              is_rem;

    assign lim       = (cap_reg > DEPTH_CNT) ? DEPTH_CNT : cap_reg;
    assign pos_m1    = in_req.position - CNT_W'(1);
    assign pos_ok    = (in_req.position != '0) && (in_req.position <= count_reg);
    assign ins_ok    = (count_reg < lim) && (in_req.position != '0)
                       && ({1'b0, in_req.position} <= ({1'b0, count_reg} + 8'd1));

    always_comb
    begin
        unique case (in_req.mode)
            MODE_INSERT: op_ok = ins_ok;
            MODE_REMOVE: op_ok = pos_ok;
            MODE_READ:   op_ok = pos_ok;
            default:     op_ok = 1'b0;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign commit    = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        launch_valid       = accept;
        launch_tok.rd_en   = ((in_req.mode == MODE_REMOVE) || (in_req.mode == MODE_READ))
                             && pos_ok;
        launch_tok.find_en = (in_req.mode == MODE_FIND);
        launch_tok.hit     = 1'b0;
        launch_tok.target  = pos_m1[IDX_W-1:0];
        launch_tok.value   = in_req.item_value;
        launch_tok.rval    = '0;
        launch_tok.fpos    = '0;
    end

    assign is_ins = (mode_reg == MODE_INSERT) && ok_reg;
    assign is_rem = (mode_reg == MODE_REMOVE) && ok_reg;
    assign res_ok = (mode_reg == MODE_FIND) ? res_reg.hit : ok_reg;

    always_comb
    begin
        count_next = count_reg;
        if (is_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (is_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_next.ok             = res_ok;
        out_next.result_value   = res_reg.rval;
        out_next.found_position = ((mode_reg == MODE_FIND) && res_reg.hit)
                                  ? ({{(CNT_W-IDX_W){1'b0}}, res_reg.fpos} + CNT_W'(1))
                                  : '0;
        out_next.count          = count_next;
        out_next.is_empty       = (count_next == '0);
        out_next.is_full        = (count_next >= lim);
    end

    always_comb
    begin
        shift.up     = commit && is_ins;
        shift.down   = commit && is_rem;
        shift.target = target_reg;
        shift.value  = value_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done_valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= in_req.mode;
            ok_reg     <= op_ok;
            target_reg <= pos_m1[IDX_W-1:0];
            value_reg  <= in_req.item_value;
        end
        if ((state_reg == ST_RUN) && done_valid)
        begin
            res_reg <= done_tok;
        end
        if (commit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign count     = count_reg;

endmodule

// File: src/positional_array_list_core.sv
// Top level of the positional array list: sequencer and a row of entry cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   in       | in_valid / in_stall   | in_req  (mode, position, item_value)
//   out      | out_valid / out_stall | out_res (ok, value, position, count, flags)
//   cfg      | cfg_valid / cfg_ready | cfg_data (capacity limit)
//
// A request is accepted only after the previous one has committed: the query walks
// the cell row one cell per cycle, then the sequencer captures its result and commits it.
// Insert and remove move every cell at or above the target in parallel in the commit cycle.
// Reset clears the entry count and loads the capacity limit with 50; entries hold
// no reset. A stalled result holds the commit; no new request is taken until it commits.
`timescale 1ns / 1ps

module positional_array_list_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  pal_pkg::pal_in_t           in_req,
    output logic                       out_valid,
    input  logic                       out_stall,
    output pal_pkg::pal_out_t          out_res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pal_pkg::CNT_W-1:0]  cfg_data
);
    import pal_pkg::*;

    logic              tok_valid [DEPTH+1];
    pal_token_t        tok       [DEPTH+1];
    logic [DATA_W-1:0] entry     [DEPTH];
    pal_shift_t        shift;
    logic [CNT_W-1:0]  count;

    pal_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_req       (in_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_res      (out_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .launch_valid (tok_valid[0]),
        .launch_tok   (tok[0]),
        .done_valid   (tok_valid[DEPTH]),
        .done_tok     (tok[DEPTH]),
        .shift        (shift),
        .count        (count)
    );

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [DATA_W-1:0] left_entry;
        logic [DATA_W-1:0] right_entry;

        if (k == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_left
            assign left_entry = entry[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_right
            assign right_entry = entry[k+1];
        end

        pal_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_index    (IDX_W'(k)),
            .count         (count),
            .shift         (shift),
            .left_entry    (left_entry),
            .right_entry   (right_entry),
            .entry         (entry[k]),
            .tok_valid_in  (tok_valid[k]),
            .tok_in        (tok[k]),
            .tok_valid_out (tok_valid[k+1]),
            .tok_out       (tok[k+1])
        );
    end

endmodule
